### src/linear_key_value_table_defines.svh
// Assertion macros used by the RTL of the key/value table.
`ifndef LINEAR_KEY_VALUE_TABLE_DEFINES_SVH
`define LINEAR_KEY_VALUE_TABLE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication: prop is checked on every edge outside reset.
`define LKVT_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error("lkvt assertion failed");
// Next-cycle implication: pre on one edge requires post on the next.
`define LKVT_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
		else $error("lkvt assertion failed");
`else
`define LKVT_ASSERT(lbl, clk, rst_n, prop)
`define LKVT_ASSERT_NEXT(lbl, clk, rst_n, pre, post)
`endif

`endif

### src/lkvt_pkg.sv
`default_nettype none

package lkvt_pkg;

	localparam int CAPACITY_DEF    = 256;
	localparam int KEY_WIDTH_DEF   = 32;
	localparam int VALUE_WIDTH_DEF = 32;

	// port field widths
	localparam int OP_W        = 3;
	localparam int KEY_PORT_W  = 32;
	localparam int VAL_PORT_W  = 32;
	localparam int POS_W       = 8;
	localparam int CNT_PORT_W  = 9;
	localparam int IN_TDATA_W  = 72;
	localparam int OUT_TDATA_W = 80;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT   = 3'd0,
		OP_UPDATE   = 3'd1,
		OP_INS_UPD  = 3'd2,
		OP_ERASE    = 3'd3,
		OP_LOOKUP   = 3'd4,
		OP_READ_IDX = 3'd5
	} op_t;

endpackage

`default_nettype wire

### src/lkvt_ram.sv
`default_nettype none

module lkvt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

### src/linear_key_value_table.sv
// Key/value table with insertion order and linear search.
// Request channel s_*: one word per request, op code in s_tuser, key, value
// and position in s_tdata. Result channel m_*: one word per request, in order.
// Keys and values live in two single-port-read RAMs (one read, one write per
// cycle, registered read); the search walks the key RAM one entry a cycle.
// Insert, update and lookup search up to the hit position, or over all
// entries on a miss, and do no search when the table is empty; erase also
// moves each entry after the hit down one place, so search and tail move
// touch each entry once. read_by_index in range reads one entry; out of
// range positions and unused codes return without a RAM read.
// Only one request is worked on at a time; s_tready is high while no request
// is in flight, so the next request can be taken in the same cycle as a
// result turns valid. A finished result sits in the output register, so
// the next request is taken while it waits; if the receiver still stalls when
// that next result is ready, the block holds it and waits.
// Reset clears the entry count and the handshake state; RAM contents are not
// cleared and are never read before being written.
`default_nettype none
`include "linear_key_value_table_defines.svh"

module linear_key_value_table #(
	parameter int CAPACITY    = lkvt_pkg::CAPACITY_DEF,
	parameter int KEY_WIDTH   = lkvt_pkg::KEY_WIDTH_DEF,
	parameter int VALUE_WIDTH = lkvt_pkg::VALUE_WIDTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// request: tdata = lookup_key[31:0], new_value[63:32], position[71:64]
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	input  wire logic [lkvt_pkg::IN_TDATA_W-1:0] s_tdata,
	// request: tuser = operation[2:0]
	input  wire logic [lkvt_pkg::OP_W-1:0]      s_tuser,
	// result: tdata = success[0], found_key[32:1], found_value[64:33],
	//         entry_count[73:65], is_empty[74], zero fill[79:75]
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	output logic [lkvt_pkg::OUT_TDATA_W-1:0]    m_tdata
);

	import lkvt_pkg::*;

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_SCAN  = 5'b00010,
		ST_SHIFT = 5'b00100,
		ST_RIDX  = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	state_t state_q, state_n;

	// request fields
	op_t                    op_q, op_n;
	logic [KEY_WIDTH-1:0]   key_q, key_n;
	logic [VALUE_WIDTH-1:0] val_q, val_n;

	logic [CNT_W-1:0] count_q, count_n;
	// next entry to read (scan or shift)
	logic [CNT_W-1:0] idx_q, idx_n;
	// read in flight: its RAM data is valid this cycle
	logic             vld_s1, vld_n;
	logic [IDX_W-1:0] idx_s1, idx_s1_n;

	// staged result
	logic                  res_ok_q, res_ok_n;
	logic [KEY_PORT_W-1:0] res_key_q, res_key_n;
	logic [VAL_PORT_W-1:0] res_val_q, res_val_n;

	// RAM ports
	logic                   rd_en;
	logic [IDX_W-1:0]       rd_addr;
	logic                   key_we, val_we;
	logic [IDX_W-1:0]       wr_addr;
	logic [KEY_WIDTH-1:0]   wr_key, key_rdata;
	logic [VALUE_WIDTH-1:0] wr_val, val_rdata;

	logic                   out_free;
	logic                   s_acc;
	op_t                    in_op;
	logic [KEY_WIDTH-1:0]   in_key;
	logic [VALUE_WIDTH-1:0] in_val;
	logic [POS_W-1:0]       in_pos;
	logic                   hit, miss;

	assign s_tready = (state_q == ST_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign in_op    = op_t'(s_tuser);
	assign in_key   = KEY_WIDTH'(s_tdata[31:0]);
	assign in_val   = VALUE_WIDTH'(s_tdata[63:32]);
	assign in_pos   = s_tdata[71:64];
	assign out_free = !m_tvalid || m_tready;

	assign hit  = vld_s1 && (key_rdata == key_q);
	assign miss = !vld_s1 && (idx_q >= count_q);

	lkvt_ram #(.WIDTH(KEY_WIDTH), .DEPTH(CAPACITY)) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (wr_addr),
		.wdata (wr_key),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (key_rdata)
	);

	lkvt_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(CAPACITY)) u_val_ram (
		.clk   (clk),
		.we    (val_we),
		.waddr (wr_addr),
		.wdata (wr_val),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (val_rdata)
	);

	always_comb begin
		state_n   = state_q;
		op_n      = op_q;
		key_n     = key_q;
		val_n     = val_q;
		count_n   = count_q;
		idx_n     = idx_q;
		vld_n     = 1'b0;
		idx_s1_n  = idx_s1;
		res_ok_n  = res_ok_q;
		res_key_n = res_key_q;
		res_val_n = res_val_q;
		rd_en     = 1'b0;
		rd_addr   = idx_q[IDX_W-1:0];
		key_we    = 1'b0;
		val_we    = 1'b0;
		wr_addr   = idx_s1;
		wr_key    = key_q;
		wr_val    = val_q;

		unique case (state_q)
			ST_IDLE: begin
				if (s_acc) begin
					op_n      = in_op;
					key_n     = in_key;
					val_n     = in_val;
					idx_n     = '0;
					res_ok_n  = 1'b0;
					res_key_n = KEY_PORT_W'(in_key);
					res_val_n = '0;
					unique case (in_op)
						OP_INSERT, OP_UPDATE, OP_INS_UPD, OP_ERASE, OP_LOOKUP: begin
							state_n = ST_SCAN;
						end
						OP_READ_IDX: begin
							if (CMP_W'(in_pos) < CMP_W'(count_q)) begin
								// position is in range, so it fits the RAM address
								rd_en   = 1'b1;
								rd_addr = IDX_W'(in_pos);
								state_n = ST_RIDX;
							end else begin
								res_key_n = '0;
								state_n   = ST_DONE;
							end
						end
						default: begin
							state_n = ST_DONE;
						end
					endcase
				end
			end

			ST_SCAN: begin
				priority if (hit) begin
					state_n = ST_DONE;
					unique case (op_q)
						OP_UPDATE, OP_INS_UPD: begin
							val_we   = 1'b1;
							res_ok_n = 1'b1;
						end
						OP_ERASE: begin
							res_ok_n = 1'b1;
							idx_n    = CNT_W'(idx_s1) + CNT_W'(1);
							state_n  = ST_SHIFT;
						end
						OP_LOOKUP: begin
							res_ok_n  = 1'b1;
							res_val_n = VAL_PORT_W'(val_rdata);
						end
						default: begin
							// insert of a present key fails
							res_ok_n = 1'b0;
						end
					endcase
				end else if (miss) begin
					state_n = ST_DONE;
					if ((op_q == OP_INSERT || op_q == OP_INS_UPD) &&
					    (count_q < CNT_W'(CAPACITY))) begin
						key_we   = 1'b1;
						val_we   = 1'b1;
						wr_addr  = count_q[IDX_W-1:0];
						count_n  = count_q + CNT_W'(1);
						res_ok_n = 1'b1;
					end
				end else if (idx_q < count_q) begin
					rd_en    = 1'b1;
					vld_n    = 1'b1;
					idx_s1_n = idx_q[IDX_W-1:0];
					idx_n    = idx_q + CNT_W'(1);
				end else begin
					// last entry compared without a hit, miss shows next cycle
					state_n = ST_SCAN;
				end
			end

			ST_SHIFT: begin
				// entry read last cycle moves down one place
				if (vld_s1) begin
					key_we  = 1'b1;
					val_we  = 1'b1;
					wr_addr = idx_s1 - IDX_W'(1);
					wr_key  = key_rdata;
					wr_val  = val_rdata;
				end
				if (idx_q < count_q) begin
					rd_en    = 1'b1;
					vld_n    = 1'b1;
					idx_s1_n = idx_q[IDX_W-1:0];
					idx_n    = idx_q + CNT_W'(1);
				end else if (!vld_s1) begin
					count_n = count_q - CNT_W'(1);
					state_n = ST_DONE;
				end
			end

			ST_RIDX: begin
				res_ok_n  = 1'b1;
				res_key_n = KEY_PORT_W'(key_rdata);
				res_val_n = VAL_PORT_W'(val_rdata);
				state_n   = ST_DONE;
			end

			ST_DONE: begin
				if (out_free) begin
					state_n = ST_IDLE;
				end
			end

			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			vld_s1   <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			state_q <= state_n;
			count_q <= count_n;
			vld_s1  <= vld_n;
			if (state_q == ST_DONE && out_free) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		op_q      <= op_n;
		key_q     <= key_n;
		val_q     <= val_n;
		idx_q     <= idx_n;
		idx_s1    <= idx_s1_n;
		res_ok_q  <= res_ok_n;
		res_key_q <= res_key_n;
		res_val_q <= res_val_n;
		if (state_q == ST_DONE && out_free) begin
			m_tdata <= {5'b0, (count_q == '0), CNT_PORT_W'(count_q),
			            res_val_q, res_key_q, res_ok_q};
		end
	end

	`LKVT_ASSERT(a_count_cap, clk, arst_n, count_q <= CNT_W'(CAPACITY))
	`LKVT_ASSERT(a_wr_not_idle, clk, arst_n, !((key_we || val_we) && state_q == ST_IDLE))
	`LKVT_ASSERT(a_wr_in_range, clk, arst_n, !(key_we || val_we) || (CNT_W'(wr_addr) <= count_q))
	`LKVT_ASSERT(a_count_step, clk, arst_n,
		$stable(count_q) || (count_q == CNT_W'($past(count_q) + CNT_W'(1))) ||
		(count_q == CNT_W'($past(count_q) - CNT_W'(1))))
	`LKVT_ASSERT_NEXT(a_out_from_done, clk, arst_n, (state_q != ST_DONE) && !m_tvalid, !m_tvalid)

endmodule

`default_nettype wire

### test/linear_key_value_table_tb.sv
`timescale 1ns / 100ps

module linear_key_value_table_tb;

	import lkvt_pkg::*;

	localparam int CAP         = CAPACITY_DEF;
	localparam int HOLD_CYCLES = 400;
	localparam int CYCLE_LIMIT = 3_000_000;
	localparam int DIR_ROWS    = 25;

	// op codes the block treats as no-ops
	localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

	// one result word, unpacked from m_tdata
	typedef struct packed {
		logic                  success;
		logic [KEY_PORT_W-1:0] found_key;
		logic [VAL_PORT_W-1:0] found_value;
		logic [CNT_PORT_W-1:0] entry_count;
		logic                  is_empty;
	} result_t;

	// one request word
	typedef struct packed {
		logic [OP_W-1:0]       op;
		logic [KEY_PORT_W-1:0] key;
		logic [VAL_PORT_W-1:0] val;
		logic [POS_W-1:0]      pos;
	} request_t;

	// directed row: request, plus a hand-written result where typed is set
	typedef struct packed {
		logic [OP_W-1:0]       op;
		logic [KEY_PORT_W-1:0] key;
		logic [VAL_PORT_W-1:0] val;
		logic [POS_W-1:0]      pos;
		logic                  typed;
		result_t               res;
	} dir_row_t;

	localparam result_t NO_RES = '0;

	// Walked in order right after reset. Rows with typed = 1 carry a result
	// that is obvious by hand (empty table, misses, first inserts, range
	// errors); the rest go through the table predictor.
	localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
		// empty table: every operation misses
		'{OP_LOOKUP,   32'h0000_0000, 32'h0000_0000, 8'd0,   1'b1,
			'{1'b0, 32'h0000_0000, 32'h0, 9'd0, 1'b1}},
		'{OP_READ_IDX, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd0,   1'b1,
			'{1'b0, 32'h0000_0000, 32'h0, 9'd0, 1'b1}},
		'{OP_UPDATE,   32'hFFFF_FFFF, 32'h0000_0001, 8'd0,   1'b1,
			'{1'b0, 32'hFFFF_FFFF, 32'h0, 9'd0, 1'b1}},
		'{OP_ERASE,    32'h0000_0005, 32'h0000_0000, 8'd0,   1'b1,
			'{1'b0, 32'h0000_0005, 32'h0, 9'd0, 1'b1}},
		// extreme keys and values
		'{OP_INSERT,   32'h0000_0000, 32'hFFFF_FFFF, 8'd0,   1'b1,
			'{1'b1, 32'h0000_0000, 32'h0, 9'd1, 1'b0}},
		'{OP_INSERT,   32'hFFFF_FFFF, 32'h0000_0000, 8'd255, 1'b1,
			'{1'b1, 32'hFFFF_FFFF, 32'h0, 9'd2, 1'b0}},
		// duplicate insert is refused
		'{OP_INSERT,   32'h0000_0000, 32'h0000_0007, 8'd0,   1'b1,
			'{1'b0, 32'h0000_0000, 32'h0, 9'd2, 1'b0}},
		'{OP_LOOKUP,   32'h0000_0000, 32'h0000_0000, 8'd0,   1'b1,
			'{1'b1, 32'h0000_0000, 32'hFFFF_FFFF, 9'd2, 1'b0}},
		'{OP_READ_IDX, 32'h1357_9BDF, 32'h0000_0000, 8'd1,   1'b1,
			'{1'b1, 32'hFFFF_FFFF, 32'h0, 9'd2, 1'b0}},
		// position past the end, far and at the boundary
		'{OP_READ_IDX, 32'hFFFF_FFFF, 32'h0000_0000, 8'd255, 1'b1,
			'{1'b0, 32'h0000_0000, 32'h0, 9'd2, 1'b0}},
		'{OP_READ_IDX, 32'hFFFF_FFFF, 32'h0000_0000, 8'd2,   1'b1,
			'{1'b0, 32'h0000_0000, 32'h0, 9'd2, 1'b0}},
		'{OP_UPDATE,   32'hFFFF_FFFF, 32'hA5A5_A5A5, 8'd0,   1'b0, NO_RES},
		// insert-or-update: update path, then insert path
		'{OP_INS_UPD,  32'h0000_0000, 32'h1234_5678, 8'd0,   1'b0, NO_RES},
		'{OP_INS_UPD,  32'h8000_0000, 32'h5A5A_5A5A, 8'd0,   1'b0, NO_RES},
		'{OP_INSERT,   32'h7FFF_FFFF, 32'h8000_0001, 8'd0,   1'b0, NO_RES},
		'{OP_LOOKUP,   32'h7FFF_FFFF, 32'h0000_0000, 8'd0,   1'b0, NO_RES},
		// erase of the head shifts the tail down
		'{OP_ERASE,    32'h0000_0000, 32'hFFFF_FFFF, 8'd0,   1'b0, NO_RES},
		'{OP_READ_IDX, 32'h0000_0000, 32'h0000_0000, 8'd0,   1'b0, NO_RES},
		// spare op codes change nothing
		'{OP_SPARE_6,  32'h0000_1234, 32'hFFFF_FFFF, 8'd255, 1'b0, NO_RES},
		'{OP_SPARE_7,  32'hDEAD_BEEF, 32'h0000_0000, 8'd0,   1'b0, NO_RES},
		// erase tail, then the new tail, then the last remaining
		'{OP_ERASE,    32'h7FFF_FFFF, 32'h0000_0000, 8'd0,   1'b0, NO_RES},
		'{OP_ERASE,    32'h8000_0000, 32'h0000_0000, 8'd0,   1'b0, NO_RES},
		'{OP_ERASE,    32'hFFFF_FFFF, 32'h0000_0000, 8'd0,   1'b0, NO_RES},
		// empty again
		'{OP_LOOKUP,   32'hFFFF_FFFF, 32'h0000_0000, 8'd0,   1'b1,
			'{1'b0, 32'hFFFF_FFFF, 32'h0, 9'd0, 1'b1}},
		'{OP_READ_IDX, 32'h0000_0000, 32'h0000_0000, 8'd0,   1'b1,
			'{1'b0, 32'h0000_0000, 32'h0, 9'd0, 1'b1}}
	};

	logic                   clk      = 1'b0;
	logic                   arst_n   = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata  = '0;
	logic [OP_W-1:0]        s_tuser  = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;

	// shadow copy of the table contents
	logic [KEY_PORT_W-1:0] shadow_keys [CAP];
	logic [VAL_PORT_W-1:0] shadow_vals [CAP];
	int                    shadow_count = 0;

	result_t pending_results [$];
	int      fail_count  = 0;
	int      cycle_count = 0;

	// idling knobs, percent of cycles; written by the stimulus only
	int tx_idle_pct  = 0;
	int rx_stall_pct = 0;
	// long receiver hold-off: stimulus bumps hold_reqs, receiver counts it out
	int hold_reqs = 0;
	int hold_seen = 0;
	int hold_left = 0;

	linear_key_value_table dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("linear_key_value_table_tb failed");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// table predictor
	// ---------------------------------------------------------------

	// position of key, or shadow_count when absent
	function automatic int shadow_find(logic [KEY_PORT_W-1:0] key);
		for (int k = 0; k < shadow_count; k++)
			if (shadow_keys[k] == key)
				return k;
		return shadow_count;
	endfunction

	function automatic logic shadow_update(logic [KEY_PORT_W-1:0] key,
			logic [VAL_PORT_W-1:0] val);
		int k;
		k = shadow_find(key);
		if (k >= shadow_count)
			return 1'b0;
		shadow_vals[k] = val;
		return 1'b1;
	endfunction

	function automatic logic shadow_insert(logic [KEY_PORT_W-1:0] key,
			logic [VAL_PORT_W-1:0] val);
		if (shadow_count >= CAP || shadow_find(key) < shadow_count)
			return 1'b0;
		shadow_keys[shadow_count] = key;
		shadow_vals[shadow_count] = val;
		shadow_count++;
		return 1'b1;
	endfunction

	// applies one request to the shadow table, returns the result word
	function automatic result_t table_apply(request_t q);
		result_t r;
		int      k;
		r = '0;
		r.found_key = q.key;
		case (q.op)
			OP_INSERT: r.success = shadow_insert(q.key, q.val);
			OP_UPDATE: r.success = shadow_update(q.key, q.val);
			OP_INS_UPD: begin
				r.success = shadow_update(q.key, q.val);
				if (!r.success)
					r.success = shadow_insert(q.key, q.val);
			end
			OP_ERASE: begin
				k = shadow_find(q.key);
				if (k < shadow_count) begin
					// close the gap
					for (int j = k + 1; j < shadow_count; j++) begin
						shadow_keys[j-1] = shadow_keys[j];
						shadow_vals[j-1] = shadow_vals[j];
					end
					shadow_count--;
					r.success = 1'b1;
				end
			end
			OP_LOOKUP: begin
				k = shadow_find(q.key);
				if (k < shadow_count) begin
					r.success     = 1'b1;
					r.found_value = shadow_vals[k];
				end
			end
			OP_READ_IDX: begin
				if (int'(q.pos) < shadow_count) begin
					r.success     = 1'b1;
					r.found_key   = shadow_keys[q.pos];
					r.found_value = shadow_vals[q.pos];
				end else begin
					r.found_key = '0;
				end
			end
			default: ;
		endcase
		r.entry_count = shadow_count[CNT_PORT_W-1:0];
		r.is_empty    = (shadow_count == 0);
		return r;
	endfunction

	// random key that is not in the table
	function automatic logic [KEY_PORT_W-1:0] absent_key();
		logic [KEY_PORT_W-1:0] k;
		k = $urandom;
		while (shadow_find(k) < shadow_count)
			k = $urandom;
		return k;
	endfunction

	// Mostly well-formed requests: keys taken from the table so that hits,
	// updates and erases happen, positions mostly in range, table kept short.
	// About one in seven is plain noise, spare op codes included.
	function automatic request_t draw_request();
		request_t q;
		int       roll;
		q.op  = OP_W'($urandom_range(7));
		q.key = $urandom;
		q.val = $urandom;
		q.pos = POS_W'($urandom_range(255));
		if ($urandom_range(99) < 15)
			return q;
		roll = $urandom_range(99);
		if (roll < 25)
			q.op = OP_INSERT;
		else if (roll < 35)
			q.op = OP_UPDATE;
		else if (roll < 50)
			q.op = OP_INS_UPD;
		else if (roll < 67)
			q.op = OP_ERASE;
		else if (roll < 85)
			q.op = OP_LOOKUP;
		else
			q.op = OP_READ_IDX;
		if (shadow_count > 24 && $urandom_range(1) == 1)
			q.op = OP_ERASE;
		if (shadow_count != 0 && $urandom_range(99) < 60)
			q.key = shadow_keys[$urandom_range(shadow_count - 1)];
		else if ($urandom_range(2) == 0)
			q.key = $urandom_range(47);	// small pool, erased keys come back
		// includes pos == count, the first position out of range
		q.pos = POS_W'($urandom_range(shadow_count));
		return q;
	endfunction

	// ---------------------------------------------------------------
	// request side
	// ---------------------------------------------------------------

	// Offers one word and waits for it to be taken. The expected result is
	// queued at acceptance, so the shadow table follows accept order.
	// tvalid is only lowered inside a gap, never between back-to-back words.
	task automatic offer_request(request_t q, logic typed, result_t typed_res);
		result_t pred;
		while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {q.pos, q.val, q.key};
		s_tuser  <= q.op;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pred = table_apply(q);
		pending_results.push_back(typed ? typed_res : pred);
	endtask

	// sender pauses until every result is back
	task automatic wait_results_drained();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic run_random(int n, int tx_pct, int rx_pct, int hold_at);
		tx_idle_pct  = tx_pct;
		rx_stall_pct = rx_pct;
		for (int i = 0; i < n; i++) begin
			if (i == hold_at)
				hold_reqs++;
			offer_request(draw_request(), 1'b0, NO_RES);
		end
		wait_results_drained();
	endtask

	task automatic offer_plain(logic [OP_W-1:0] op, logic [KEY_PORT_W-1:0] key,
			logic [POS_W-1:0] pos);
		request_t q;
		q.op  = op;
		q.key = key;
		q.val = $urandom;
		q.pos = pos;
		offer_request(q, 1'b0, NO_RES);
	endtask

	// ---------------------------------------------------------------
	// result side
	// ---------------------------------------------------------------

	// random stalls, plus the long counted hold-off on request
	always @(posedge clk) begin
		if (hold_seen != hold_reqs) begin
			hold_seen = hold_reqs;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= !(rx_stall_pct != 0 && $urandom_range(99) < rx_stall_pct);
		end
	end

	// compare each accepted result word with the oldest expectation
	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.success     = m_tdata[0];
			got.found_key   = m_tdata[32:1];
			got.found_value = m_tdata[64:33];
			got.entry_count = m_tdata[73:65];
			got.is_empty    = m_tdata[74];
			if (pending_results.size() == 0) begin
				$error("result word with nothing expected: %h", m_tdata);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (got.success !== want.success) begin
					$error("success: expected %h, got %h", want.success, got.success);
					fail_count++;
				end
				if (got.found_key !== want.found_key) begin
					$error("found_key: expected %h, got %h", want.found_key, got.found_key);
					fail_count++;
				end
				if (got.found_value !== want.found_value) begin
					$error("found_value: expected %h, got %h",
						want.found_value, got.found_value);
					fail_count++;
				end
				if (got.entry_count !== want.entry_count) begin
					$error("entry_count: expected %0d, got %0d",
						want.entry_count, got.entry_count);
					fail_count++;
				end
				if (got.is_empty !== want.is_empty) begin
					$error("is_empty: expected %h, got %h", want.is_empty, got.is_empty);
					fail_count++;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// test sequence
	// ---------------------------------------------------------------
	initial begin
		request_t q;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table, no idling
		for (int i = 0; i < DIR_ROWS; i++) begin
			q.op  = DIR_TABLE[i].op;
			q.key = DIR_TABLE[i].key;
			q.val = DIR_TABLE[i].val;
			q.pos = DIR_TABLE[i].pos;
			offer_request(q, DIR_TABLE[i].typed, DIR_TABLE[i].res);
		end
		wait_results_drained();

		// no idling; a long receiver hold-off partway fills the output
		// register and then backs up the request side
		run_random(200, 0, 0, 60);
		run_random(150, 82, 0, -1);
		run_random(150, 0, 82, -1);
		run_random(150, 25, 25, -1);

		// fill to capacity: full-table cases, longest searches and shifts
		tx_idle_pct  = 25;
		rx_stall_pct = 25;
		while (shadow_count < CAP)
			offer_plain(OP_INSERT, absent_key(), POS_W'($urandom_range(255)));
		offer_plain(OP_INSERT, absent_key(), 8'd0);
		offer_plain(OP_INS_UPD, absent_key(), 8'd0);
		offer_plain(OP_INS_UPD, shadow_keys[0], 8'd0);
		offer_plain(OP_LOOKUP, shadow_keys[CAP-1], 8'd0);
		offer_plain(OP_READ_IDX, $urandom, 8'd255);
		offer_plain(OP_UPDATE, shadow_keys[CAP-1], 8'd255);
		offer_plain(OP_ERASE, shadow_keys[0], 8'd0);
		offer_plain(OP_INSERT, absent_key(), 8'd0);
		offer_plain(OP_READ_IDX, $urandom, 8'd255);
		// drain back down, erase of random entries with some lookups
		while (shadow_count > 8) begin
			if ($urandom_range(4) == 0)
				offer_plain(OP_LOOKUP, shadow_keys[$urandom_range(shadow_count - 1)],
					POS_W'($urandom_range(255)));
			else
				offer_plain(OP_ERASE, shadow_keys[$urandom_range(shadow_count - 1)],
					POS_W'($urandom_range(255)));
		end
		wait_results_drained();

		// grace period for any stray word
		repeat (2 * CAP + 8) @(posedge clk);
		if (fail_count == 0)
			$display("linear_key_value_table_tb passed");
		else
			$display("linear_key_value_table_tb failed");
		$finish;
	end

endmodule
